FILE: sv/bpd_pkg.sv
// Package for the bounded positional deque: sizes, command and status codes,
// word structs and the shift control that drives the cell chains.
// No dependencies.
package bpd_pkg;

    localparam int DEPTH = 128;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = 8;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_PEEK       = 3'd7
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'd0,
        SHIFT_INS  = 2'd1,
        SHIFT_DEL  = 2'd2
    } shift_op_t;

    typedef struct packed {
        cmd_e_t             command;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [7:0]         item_count;
        status_t            status;
    } rsp_word_t;

    typedef struct packed {
        shift_op_t          op;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] value;
    } shift_ctrl_t;

endpackage

FILE: sv/bpd_cell.sv
// One storage cell of a deque chain: holds one word, loads, shifts or holds.
// Depends on bpd_pkg.
module bpd_cell
    import bpd_pkg::*;
(
    input  logic               clk,
    input  shift_op_t          op,
    input  logic               is_at,
    input  logic               is_above,
    input  logic signed [31:0] value,
    input  logic signed [31:0] left_word,
    input  logic signed [31:0] right_word,
    output logic signed [31:0] word_q,
    output logic signed [31:0] word_next
);

    logic signed [31:0] word_reg;

    always_comb
    begin
        word_next = word_reg;
        unique case (op)
            SHIFT_INS:
            begin
                if (is_above)
                begin
                    word_next = left_word;
                end
                else if (is_at)
                begin
                    word_next = value;
                end
            end
            SHIFT_DEL:
            begin
                if (is_above || is_at)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule

FILE: sv/bpd_chain.sv
// Row of DEPTH cells; cell 0 is the head. Each cell gets its position flags
// from the shared shift control. Depends on bpd_pkg and bpd_cell.
module bpd_chain
    import bpd_pkg::*;
(
    input  logic               clk,
    input  shift_ctrl_t        ctrl,
    output logic signed [31:0] head_q,
    output logic signed [31:0] head_next
);

    logic signed [31:0] word_q    [DEPTH];
    logic signed [31:0] word_next [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);
        logic signed [31:0] left_w;
        logic signed [31:0] right_w;

        // end cells never take from outside the row
        if (i == 0)
        begin : g_first
            assign left_w = word_q[i];
        end
        else
        begin : g_left
            assign left_w = word_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = word_q[i];
        end
        else
        begin : g_right
            assign right_w = word_q[i+1];
        end

        bpd_cell u_cell (
            .clk        (clk),
            .op         (ctrl.op),
            .is_at      (ctrl.idx == CELL_IDX),
            .is_above   (CELL_IDX > ctrl.idx),
            .value      (ctrl.value),
            .left_word  (left_w),
            .right_word (right_w),
            .word_q     (word_q[i]),
            .word_next  (word_next[i])
        );
    end

    assign head_q    = word_q[0];
    assign head_next = word_next[0];

endmodule

FILE: sv/bounded_positional_deque_top.sv
// Bounded positional deque, top level. The response word is registered and
// shows in the cycle after its command word is taken. Throughput: one command
// per cycle while cmd_stall is low; every command, insert and erase included,
// completes as it is taken since all cells shift in parallel. Reset (rst_n,
// async) empties the deque and clears rsp_valid; rsp payload, cells are kept.
// Depends on bpd_pkg and bpd_chain.
module bounded_positional_deque_top
    import bpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    // Two chains hold the same entries. Chain A is front aligned (cell 0 is the
    // front), chain B is back aligned (cell 0 is the back). Both ends are then
    // always at a fixed cell, so no wide select over the cells is needed. An
    // insert or erase at logical position p maps to cell p in A and to the
    // mirrored cell in B.

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_word_t          rsp_reg;
    rsp_word_t          rsp_next;

    shift_ctrl_t        ctrl_a;
    shift_ctrl_t        ctrl_b;
    logic signed [31:0] a_head_q;
    logic signed [31:0] a_head_next;
    logic signed [31:0] b_head_q;
    logic signed [31:0] b_head_next;

    logic               accept;
    logic               full;
    logic               empty;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [IDX_W-1:0]   cnt_idx;
    logic [IDX_W-1:0]   pos_idx;
    logic [IDX_W-1:0]   mir_ins_idx;
    logic [IDX_W-1:0]   mir_del_idx;
    logic signed [31:0] popped;
    status_t            status;

    // the response register frees in the same cycle it is taken
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(cmd.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign cnt_idx = IDX_W'(count_reg);
    assign pos_idx = IDX_W'(pos_ext);
    // mirrored cells in B: count - p for insert, count - 1 - p for erase
    assign mir_ins_idx = IDX_W'(cnt_ext - pos_ext);
    assign mir_del_idx = IDX_W'(cnt_ext - pos_ext - CMP_W'(1));

    always_comb
    begin
        count_next   = count_reg;
        popped       = '0;
        status       = ST_OK;
        ctrl_a.op    = SHIFT_HOLD;
        ctrl_a.idx   = '0;
        ctrl_a.value = cmd.value;
        ctrl_b.op    = SHIFT_HOLD;
        ctrl_b.idx   = '0;
        ctrl_b.value = cmd.value;

        if (accept)
        begin
            unique case (cmd.command)
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        ctrl_a.op  = SHIFT_INS;
                        ctrl_a.idx = cnt_idx;
                        ctrl_b.op  = SHIFT_INS;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        ctrl_a.op  = SHIFT_INS;
                        ctrl_b.op  = SHIFT_INS;
                        ctrl_b.idx = cnt_idx;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        popped     = a_head_q;
                        ctrl_a.op  = SHIFT_DEL;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        popped     = b_head_q;
                        ctrl_b.op  = SHIFT_DEL;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_INSERT:
                begin
                    // full check first, then range; position == count appends
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else if (pos_ext > cnt_ext)
                    begin
                        status = ST_RANGE;
                    end
                    else
                    begin
                        ctrl_a.op  = SHIFT_INS;
                        ctrl_a.idx = pos_idx;
                        ctrl_b.op  = SHIFT_INS;
                        ctrl_b.idx = mir_ins_idx;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_ERASE:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (pos_ext >= cnt_ext)
                    begin
                        status = ST_RANGE;
                    end
                    else
                    begin
                        ctrl_a.op  = SHIFT_DEL;
                        ctrl_a.idx = pos_idx;
                        ctrl_b.op  = SHIFT_DEL;
                        ctrl_b.idx = mir_del_idx;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                CMD_PEEK:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    // response built from the post-command head cells
    always_comb
    begin
        rsp_next.popped_value = popped;
        rsp_next.item_count   = 8'(count_next);
        rsp_next.status       = status;
        if (count_next != '0)
        begin
            rsp_next.front_value = a_head_next;
            rsp_next.back_value  = b_head_next;
        end
        else
        begin
            rsp_next.front_value = '0;
            rsp_next.back_value  = '0;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    bpd_chain u_chain_a (
        .clk       (clk),
        .ctrl      (ctrl_a),
        .head_q    (a_head_q),
        .head_next (a_head_next)
    );

    bpd_chain u_chain_b (
        .clk       (clk),
        .ctrl      (ctrl_b),
        .head_q    (b_head_q),
        .head_next (b_head_next)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/bpd_checker.sv
// Port-level checks for the bounded positional deque, bound to the top level.
// Depends on bpd_pkg and bounded_positional_deque_top.
module bpd_checker
    import bpd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input cmd_word_t cmd,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_word_t rsp
);

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed under stall");

    // response valid in the cycle after an accepted command
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> rsp_valid)
        else $error("no response one cycle after command");

    // command side only stalls behind a pending response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("command stall without pending response");

    // empty deque shows zero ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.item_count == 8'd0) |->
            (rsp.front_value == 32'sd0) && (rsp.back_value == 32'sd0))
        else $error("nonzero end word on empty deque");

    // clear always empties with ok status
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.command == CMD_CLEAR) |=>
            (rsp.item_count == 8'd0) && (rsp.status == ST_OK))
        else $error("clear did not empty the deque");

endmodule

bind bounded_positional_deque_top bpd_checker u_bpd_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for bounded_positional_deque_top: a directed table, then
// random phases with random handshake idling, checked against typed words or a shadow deque.
// Depends on bpd_pkg and the deque RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SHOW_MAX     = 10;
    localparam int DIR_ROWS     = 25;
    localparam int PHASES       = 6;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

    typedef struct {
        cmd_word_t w;
        bit        typed;
        rsp_word_t rsp;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    // shadow copy of the deque: cell 0 is the front
    logic signed [31:0] shadow_cells [DEPTH];
    int                 shadow_count = 0;

    rsp_word_t pending_rsp_q [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        no_idle = 1'b0;

    dir_row_t  dir_table [DIR_ROWS];

    bounded_positional_deque_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic rsp_word_t mk_rsp(logic signed [31:0] popped, logic signed [31:0] front,
                                         logic signed [31:0] back, int count, status_t st);
        rsp_word_t r;
        r.popped_value = popped;
        r.front_value  = front;
        r.back_value   = back;
        r.item_count   = 8'(count);
        r.status       = st;
        return r;
    endfunction

    // One command against the shadow deque; returns the response word it should give.
    // A rejected command leaves the shadow untouched.
    function automatic rsp_word_t apply_to_shadow(cmd_word_t w);
        rsp_word_t r;
        int        n;
        int        p;
        int        i;
        r = '0;
        r.status = ST_OK;
        n = shadow_count;
        p = int'(w.position);
        unique case (w.command)
            CMD_PUSH_BACK:
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_cells[n] = w.value;
                    shadow_count = n + 1;
                end
            CMD_PUSH_FRONT:
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = n; i > 0; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[0] = w.value;
                    shadow_count = n + 1;
                end
            CMD_POP_FRONT:
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped_value = shadow_cells[0];
                    for (i = 0; i + 1 < n; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_count = n - 1;
                end
            CMD_POP_BACK:
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped_value = shadow_cells[n - 1];
                    shadow_count = n - 1;
                end
            CMD_INSERT:
                // full wins over a bad position; position == count appends
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else if (p > n)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = n; i > p; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[p] = w.value;
                    shadow_count = n + 1;
                end
            CMD_ERASE:
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (p >= n)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = p; i + 1 < n; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_count = n - 1;
                end
            CMD_CLEAR:
                shadow_count = 0;
            default:
                if (n == 0)
                    r.status = ST_EMPTY;
        endcase
        if (shadow_count > 0)
        begin
            r.front_value = shadow_cells[0];
            r.back_value  = shadow_cells[shadow_count - 1];
        end
        r.item_count = 8'(shadow_count);
        return r;
    endfunction

    // Drive one command word after a random gap, wait for it to be taken, then
    // queue the response expected for it.
    task automatic send_word(cmd_word_t w, bit typed, rsp_word_t typed_rsp);
        int        gap;
        rsp_word_t predicted;
        gap = idle_cycles();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = apply_to_shadow(w);
        pending_rsp_q.insert(pending_rsp_q.size(), typed ? typed_rsp : predicted);
    endtask

    // Hold the sender off until every queued response has come back.
    task automatic drain_responses();
        cmd_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_word_t random_word(phase_t ph);
        cmd_word_t   w;
        int          r;
        logic [2:0]  code;
        r = $urandom_range(0, 99);
        unique case (ph)
            PH_FILL:
                code = (r < 40) ? CMD_PUSH_BACK : (r < 60) ? CMD_PUSH_FRONT :
                       (r < 85) ? CMD_INSERT : (r < 90) ? CMD_POP_FRONT :
                       (r < 94) ? CMD_POP_BACK : (r < 97) ? CMD_ERASE : CMD_PEEK;
            PH_DRAIN:
                code = (r < 30) ? CMD_POP_FRONT : (r < 55) ? CMD_POP_BACK :
                       (r < 85) ? CMD_ERASE : (r < 92) ? CMD_PUSH_BACK :
                       (r < 95) ? CMD_INSERT : CMD_PEEK;
            default:
            begin
                // clear is kept rare so the deque still gets deep
                code = 3'($urandom_range(0, 6));
                if (code == CMD_CLEAR)
                    code = CMD_PEEK;
                if (r < 2)
                    code = CMD_CLEAR;
            end
        endcase
        w.command = cmd_e_t'(code);
        r = $urandom_range(0, 9);
        if (r < 6)
            w.position = 8'($urandom_range(0, shadow_count));
        else if (r < 8)
            w.position = 8'(shadow_count);
        else if (r < 9)
            w.position = 8'(shadow_count + 1);
        else
            w.position = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 31);
        unique case (r)
            0:       w.value = 32'sh8000_0000;
            1:       w.value = 32'sh7fff_ffff;
            2:       w.value = 32'sh0000_0000;
            3:       w.value = -32'sd1;
            default: w.value = $urandom;
        endcase
        return w;
    endfunction

    function automatic dir_row_t dir_row(cmd_e_t c, logic signed [31:0] v, int p,
                                         bit typed, rsp_word_t r);
        dir_row_t d;
        d.w.command  = c;
        d.w.value    = v;
        d.w.position = 8'(p);
        d.typed      = typed;
        d.rsp        = r;
        return d;
    endfunction

    // Response side: random stall before each word, then take it.
    initial
    begin : rsp_side
        int hold;
        forever
        begin
            hold = idle_cycles();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // Checker: every taken response word against the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                if (mismatch_count < SHOW_MAX)
                    $display("unexpected response word: pop %0d front %0d back %0d %s %0d %0d",
                             rsp.popped_value, rsp.front_value, rsp.back_value,
                             "cnt/st", rsp.item_count, rsp.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp_q[0];
                pending_rsp_q.delete(0);
                if (rsp.popped_value !== want.popped_value ||
                    rsp.front_value !== want.front_value ||
                    rsp.back_value !== want.back_value ||
                    rsp.item_count !== want.item_count ||
                    rsp.status !== want.status)
                begin
                    if (mismatch_count < SHOW_MAX)
                    begin
                        $display("mismatch: want pop %0d front %0d back %0d cnt %0d st %0d",
                                 want.popped_value, want.front_value, want.back_value,
                                 want.item_count, want.status);
                        $display("          got  pop %0d front %0d back %0d cnt %0d st %0d",
                                 rsp.popped_value, rsp.front_value, rsp.back_value,
                                 rsp.item_count, rsp.status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stim_main
        phase_t    plan [PHASES];
        int        plan_len [PHASES];
        bit        plan_quiet [PHASES];
        int        ph;
        int        k;
        rsp_word_t none;
        none = '0;

        // Directed table. Typed responses only where obvious; the rest use the shadow.
        dir_table[0]  = dir_row(CMD_PEEK, 0, 0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY));
        dir_table[1]  = dir_row(CMD_POP_FRONT, 0, 0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY));
        dir_table[2]  = dir_row(CMD_POP_BACK, 0, 0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY));
        dir_table[3]  = dir_row(CMD_ERASE, 0, 0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY));
        dir_table[4]  = dir_row(CMD_INSERT, 5, 1, 1, mk_rsp(0, 0, 0, 0, ST_RANGE));
        dir_table[5]  = dir_row(CMD_PUSH_BACK, 32'sh7fff_ffff, 0, 1,
                                mk_rsp(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, ST_OK));
        dir_table[6]  = dir_row(CMD_PUSH_FRONT, 32'sh8000_0000, 0, 1,
                                mk_rsp(0, 32'sh8000_0000, 32'sh7fff_ffff, 2, ST_OK));
        dir_table[7]  = dir_row(CMD_INSERT, -32'sd1, 2, 0, none);          // append at count
        dir_table[8]  = dir_row(CMD_INSERT, 32'sh5555_5555, 1, 0, none);   // middle insert
        dir_table[9]  = dir_row(CMD_INSERT, 7, 5, 0, none);                // past count
        dir_table[10] = dir_row(CMD_INSERT, 32'shaaaa_aaaa, 255, 0, none);
        dir_table[11] = dir_row(CMD_ERASE, 0, 4, 0, none);                 // at count
        dir_table[12] = dir_row(CMD_ERASE, 0, 255, 0, none);
        dir_table[13] = dir_row(CMD_ERASE, 0, 1, 0, none);
        dir_table[14] = dir_row(CMD_PEEK, 0, 0, 0, none);
        dir_table[15] = dir_row(CMD_POP_BACK, 0, 0, 0, none);
        dir_table[16] = dir_row(CMD_POP_FRONT, 0, 0, 0, none);
        dir_table[17] = dir_row(CMD_ERASE, 0, 0, 0, none);                 // last entry
        dir_table[18] = dir_row(CMD_PUSH_FRONT, 0, 0, 0, none);
        dir_table[19] = dir_row(CMD_POP_FRONT, 0, 0, 0, none);             // last entry
        dir_table[20] = dir_row(CMD_PUSH_BACK, 32'shaaaa_aaaa, 0, 0, none);
        dir_table[21] = dir_row(CMD_CLEAR, 0, 0, 1, mk_rsp(0, 0, 0, 0, ST_OK));
        dir_table[22] = dir_row(CMD_CLEAR, 0, 0, 1, mk_rsp(0, 0, 0, 0, ST_OK));
        dir_table[23] = dir_row(CMD_INSERT, 32'sh1234_5678, 0, 0, none);   // insert into empty
        dir_table[24] = dir_row(CMD_POP_BACK, 0, 0, 0, none);              // last entry

        // Random plan: fill to full, drain to empty, mixed traffic in between.
        plan = '{PH_FILL, PH_DRAIN, PH_MIX, PH_FILL, PH_MIX, PH_DRAIN};
        plan_len = '{250, 250, 300, 250, 300, 300};
        plan_quiet = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_word(dir_table[k].w, dir_table[k].typed, dir_table[k].rsp);

        for (ph = 0; ph < PHASES; ph++)
        begin
            // sender pauses for an empty pipe between phases
            drain_responses();
            no_idle = plan_quiet[ph];
            for (k = 0; k < plan_len[ph]; k++)
                send_word(random_word(plan[ph]), 1'b0, none);
        end
        cmd_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (pending_rsp_q.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: files.f
sv/bpd_pkg.sv
sv/bpd_cell.sv
sv/bpd_chain.sv
sv/bounded_positional_deque_top.sv
sv/bpd_checker.sv
sim/testbench.sv
